[src/huffman_tree_walk_decoder_top_defines.svh]
// assertion macros for the huffman tree-walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HTWD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define HTWD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/htwd_pkg.sv]
// types and constants shared by the huffman tree-walk decoder
`default_nettype none

package htwd_pkg;

  localparam int IDX_W = 9;
  localparam int SYM_W = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int CNT_W = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DECODE  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // one request
  typedef struct packed {
    cmd_e                     command;
    idx_t                     node_index;
    idx_t                     left_child;
    idx_t                     right_child;
    sym_t                     node_symbol;
    logic                     node_is_leaf;
    logic [BITS_PER_BYTE-1:0] data_byte;
    cnt_t                     bit_count;
  } in_t;

  // one decoded symbol
  typedef struct packed {
    sym_t symbol;
    logic last;
  } out_t;

  // one node table entry
  typedef struct packed {
    logic leaf;
    sym_t sym;
    idx_t right;
    idx_t left;
  } node_t;

endpackage

`default_nettype wire

[src/huffman_tree_walk_decoder_top.sv]
// huffman tree-walk decoder: node table memory, cursor and bit walker
//
// Requests enter on req_i when start is high and busy is low. A load
// writes one node table entry and a restart puts the cursor back on the
// root; both finish in the cycle they are taken and leave busy low. A
// decode with n valid bits (n saturated to 8, n = 0 does nothing) holds
// busy through these steps: a fetch of the node under the cursor, a
// walk step per bit in which the registered table read of the current
// node selects the child and issues the read of that child, a leaf test
// after the last move, and a step to release the held symbol. The chain
// of dependent node table reads, one per bit, sets the busy time.
// Each decoded symbol appears on res_o for exactly one cycle with
// res_valid_o high; one symbol is held back so that the final symbol of
// the request can carry last. A symbol shows once the next leaf or the
// end of the walk frees it and res_o has registered it; the last one
// appears in the first cycle with busy low. The receiver cannot
// stall. Reset clears the cursor to the root and drops any result in
// flight; the node table holds no defined contents until loaded, so no
// clearing pass is needed.
`default_nettype none

`include "huffman_tree_walk_decoder_top_defines.svh"

module huffman_tree_walk_decoder_top
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT = 512
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  output logic      busy,
  input  wire  in_t req_i,
  output logic      res_valid_o,
  output out_t      res_o
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic in_range(idx_t idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  logic [1:0] state_q, state_d;
  idx_t       cursor_q, cursor_d;
  cnt_t       rem_q, rem_d;
  logic [BITS_PER_BYTE-1:0] sh_q, sh_d;
  logic       chk_q, chk_d;
  logic       oor_q, oor_d;
  logic       pend_v_q, pend_v_d;
  sym_t       pend_q, pend_d;
  node_t      root_q;
  logic       res_valid_q, res_valid_d;
  out_t       res_q, res_d;

  node_t      mem [NODE_COUNT];
  node_t      rd_q;
  logic       re;
  idx_t       raddr;
  logic       we;

  logic       accept;
  cnt_t       n_sat;
  node_t      cur, base;
  logic       hit;
  idx_t       nxt_idx;
  node_t      wdata;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign n_sat  = (req_i.bit_count > cnt_t'(BITS_PER_BYTE)) ? cnt_t'(BITS_PER_BYTE)
                                                            : req_i.bit_count;

  // load entry assembly
  assign wdata = '{leaf:  req_i.node_is_leaf,
                   sym:   req_i.node_symbol,
                   right: req_i.right_child,
                   left:  req_i.left_child};
  assign we = accept && (req_i.command == CMD_LOAD) && in_range(req_i.node_index);

  // node under the cursor, out-of-table entries read as zero
  assign cur     = oor_q ? '0 : rd_q;
  assign hit     = chk_q && cur.leaf;
  assign base    = hit ? root_q : cur;
  assign nxt_idx = sh_q[0] ? base.right : base.left;

  // walk control
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    chk_d       = chk_q;
    oor_d       = oor_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    re          = 1'b0;
    raddr       = cursor_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.command)
            CMD_DECODE: begin
              if (n_sat != '0) begin
                state_d = ST_FETCH;
                rem_d   = n_sat;
                sh_d    = req_i.data_byte;
                chk_d   = 1'b0;
                raddr   = cursor_q;
                re      = in_range(cursor_q);
                oor_d   = !in_range(cursor_q);
              end
            end
            CMD_RESTART: cursor_d = '0;
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        // leaf reached by the previous move
        if (hit) begin
          if (pend_v_q) begin
            res_valid_d = 1'b1;
            res_d       = '{symbol: pend_q, last: 1'b0};
          end
          pend_v_d = 1'b1;
          pend_d   = cur.sym;
          cursor_d = '0;
        end
        // next move
        if (rem_q != '0) begin
          raddr    = nxt_idx;
          re       = in_range(nxt_idx);
          oor_d    = !in_range(nxt_idx);
          cursor_d = nxt_idx;
          rem_d    = rem_q - cnt_t'(1);
          sh_d     = sh_q >> 1;
          chk_d    = 1'b1;
        end else begin
          state_d = ST_DONE;
          chk_d   = 1'b0;
        end
      end
      ST_DONE: begin
        if (pend_v_q) begin
          res_valid_d = 1'b1;
          res_d       = '{symbol: pend_q, last: 1'b1};
        end
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // node table, one write or one read a cycle, loads only while idle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[AW'(req_i.node_index)] <= wdata;
    end
    if (re) begin
      rd_q <= mem[AW'(raddr)];
    end
  end

  // root copy so a leaf hit restarts without another read
  always_ff @(posedge clk_i) begin
    if (accept && (req_i.command == CMD_LOAD) && (req_i.node_index == '0)) begin
      root_q <= wdata;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      chk_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      chk_q       <= chk_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    oor_q  <= oor_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `HTWD_ASSERT_NXT(a_decode_goes_busy,
    start && !busy && (req_i.command == CMD_DECODE) && (req_i.bit_count != '0),
    busy, "decode with bits did not start a walk")
  `HTWD_ASSERT_IMP(a_no_pending_when_idle, state_q == ST_IDLE, !pend_v_q,
    "held symbol left over after a request")
  `HTWD_ASSERT_IMP(a_last_ends_request, res_valid_o && res_o.last, !busy,
    "final symbol shown while the walk still runs")
  `HTWD_ASSERT_IMP(a_mid_result_while_busy, res_valid_o && !res_o.last, busy,
    "non-final symbol shown after the walk ended")

endmodule

`default_nettype wire
